[hw/rtl/epsm_pkg.sv]
// ---------------------------------------------------------------------------
// epsm_pkg
// shared constants for the encoder pulse speed meter
// ---------------------------------------------------------------------------
package epsm_pkg;

    localparam int RING_DEPTH_DEF = 8;

    localparam logic [15:0] STOP_TIME_RST = 16'd500;

    // 1000 ms/s * 256 fraction steps = 125 << 11
    localparam logic [6:0] RATE_MULT  = 7'd125;
    localparam int         RATE_SHIFT = 11;

    localparam int SPEED_W = 24;
    localparam int QUOT_W  = SPEED_W - 1;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;

    localparam logic signed [1:0] STEP_FWD  = 2'sb01;
    localparam logic signed [1:0] STEP_REV  = 2'sb11;
    localparam logic signed [1:0] STEP_NONE = 2'sb00;

endpackage

[hw/rtl/encoder_pulse_speed_meter_top.sv]
// ---------------------------------------------------------------------------
// encoder_pulse_speed_meter_top
// single-channel encoder pulse counter with windowed speed over a sample ring
// ---------------------------------------------------------------------------
// sequence: while the ring is not full a beat only updates the count; once it
//   is full, two ring reads, a multiply and a 23-step divide give the speed
// flow: a new beat is taken only after the result of the last one is handed on,
//   held by the restoring divider and the single ring read port
// reset: synchronous active-low aresetn clears count, ring fill and slot,
//   direction to forward, stop time to 500 ms; ring contents are not cleared
module encoder_pulse_speed_meter_top
    import epsm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_sensor_level,
    input  logic [31:0]               s_time_ms,
    input  logic signed [1:0]         s_speed_sign,
    input  logic                      s_clear,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [1:0]         m_pulse_step,
    output logic signed [31:0]        m_pulse_total,
    output logic                      m_sample_event,
    output logic signed [SPEED_W-1:0] m_speed,
    output logic                      m_speed_valid
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
    localparam int PROD_W = 32 + 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_RD_NEW,
        ST_RD_OLD,
        ST_GET,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [15:0]         stop_time_reg;
    logic [31:0]         pulse_count_reg;
    logic                last_level_reg;
    logic                going_fwd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [31:0]         last_edge_reg;

    logic                in_level_reg;
    logic [31:0]         in_time_reg;
    logic signed [1:0]   in_sign_reg;
    logic                in_clear_reg;

    logic signed [1:0]   step_reg;
    logic                event_reg;
    logic                full_reg;
    logic signed [SPEED_W-1:0] speed_reg;

    logic [63:0]         ring_mem [RING_DEPTH];
    logic [63:0]         rd_data_reg;
    logic [SLOT_W-1:0]   rd_addr;
    logic                ring_we;

    logic [63:0]         newest_reg;
    logic                neg_reg;
    logic                dp_zero_reg;
    logic [31:0]         mag_reg;
    logic [31:0]         dt_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                ovf_reg;
    logic [32:0]         rem_reg;
    logic [QUOT_W-1:0]   low_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [4:0]          div_cnt_reg;

    // per-poll update
    logic [31:0]         cnt_base;
    logic                fwd_base;
    logic                fwd_next;
    logic [SLOT_W-1:0]   slot_base;
    logic [FILL_W-1:0]   fill_base;
    logic [31:0]         edge_base;
    logic                is_edge;
    logic [31:0]         cnt_next;
    logic [SLOT_W-1:0]   slot_next;
    logic [FILL_W-1:0]   fill_next;
    logic [31:0]         edge_next;
    logic [31:0]         idle_time;
    logic                stop_hit;
    logic [SLOT_W-1:0]   newest_slot;

    logic [31:0]         dp;
    logic [32:0]         rem_shift;
    logic                rem_ge;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        cnt_base  = in_clear_reg ? 32'd0 : pulse_count_reg;
        fwd_base  = in_clear_reg ? 1'b1 : going_fwd_reg;
        slot_base = in_clear_reg ? '0 : slot_reg;
        fill_base = in_clear_reg ? '0 : fill_reg;
        edge_base = in_clear_reg ? in_time_reg : last_edge_reg;

        if (in_sign_reg == STEP_FWD) begin
            fwd_next = 1'b1;
        end else if (in_sign_reg[1]) begin
            fwd_next = 1'b0;
        end else begin
            fwd_next = fwd_base;
        end

        is_edge   = (in_level_reg != last_level_reg);
        idle_time = in_time_reg - edge_base;
        stop_hit  = (idle_time > {16'd0, stop_time_reg});

        cnt_next  = cnt_base;
        slot_next = slot_base;
        fill_next = fill_base;
        edge_next = edge_base;
        if (is_edge) begin
            cnt_next  = fwd_next ? cnt_base + 32'd1 : cnt_base - 32'd1;
            slot_next = (slot_base == SLOT_LAST) ? '0 : slot_base + 1'b1;
            fill_next = (fill_base == FILL_FULL) ? fill_base : fill_base + 1'b1;
            edge_next = in_time_reg;
        end else if (stop_hit) begin
            slot_next = '0;
            fill_next = '0;
            edge_next = in_time_reg;
        end
    end

    assign newest_slot = (slot_reg == '0) ? SLOT_LAST : slot_reg - 1'b1;
    assign rd_addr     = (state_reg == ST_RD_NEW) ? newest_slot : slot_reg;
    assign ring_we     = (state_reg == ST_UPDATE) && is_edge;

    // ring of {time, count} samples
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_base] <= {in_time_reg, cnt_next};
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    assign dp        = newest_reg[31:0] - rd_data_reg[31:0];
    assign rem_shift = {rem_reg[31:0], low_reg[QUOT_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dt_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            stop_time_reg   <= STOP_TIME_RST;
            pulse_count_reg <= 32'd0;
            last_level_reg  <= 1'b0;
            going_fwd_reg   <= 1'b1;
            slot_reg        <= '0;
            fill_reg        <= '0;
            last_edge_reg   <= 32'd0;
            m_valid         <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                stop_time_reg <= cfg_wdata;
            end
            if (m_valid && m_ready && (state_reg != ST_DONE)) begin
                m_valid <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_level_reg <= s_sensor_level;
                        in_time_reg  <= s_time_ms;
                        in_sign_reg  <= s_speed_sign;
                        in_clear_reg <= s_clear;
                        state_reg    <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    pulse_count_reg <= cnt_next;
                    going_fwd_reg   <= fwd_next;
                    slot_reg        <= slot_next;
                    fill_reg        <= fill_next;
                    last_edge_reg   <= edge_next;
                    last_level_reg  <= in_level_reg;
                    event_reg       <= is_edge;
                    step_reg        <= !is_edge ? STEP_NONE : (fwd_next ? STEP_FWD : STEP_REV);
                    full_reg        <= (fill_next == FILL_FULL);
                    speed_reg       <= '0;
                    state_reg       <= (fill_next == FILL_FULL) ? ST_RD_NEW : ST_DONE;
                end
                ST_RD_NEW: begin
                    state_reg <= ST_RD_OLD;
                end
                ST_RD_OLD: begin
                    newest_reg <= rd_data_reg;
                    state_reg  <= ST_GET;
                end
                ST_GET: begin
                    neg_reg     <= dp[31];
                    dp_zero_reg <= (dp == 32'd0);
                    mag_reg     <= dp[31] ? (32'd0 - dp) : dp;
                    dt_reg      <= newest_reg[63:32] - rd_data_reg[63:32];
                    state_reg   <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(mag_reg) * PROD_W'(RATE_MULT);
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    // quotient saturates iff prod << 11 >= dt << 23
                    ovf_reg     <= ({5'd0, prod_reg} >= {dt_reg, 12'd0});
                    rem_reg     <= {6'd0, prod_reg[PROD_W-1:12]};
                    low_reg     <= {prod_reg[11:0], {RATE_SHIFT{1'b0}}};
                    quot_reg    <= '0;
                    div_cnt_reg <= 5'(QUOT_W - 1);
                    if (dp_zero_reg || ({5'd0, prod_reg} >= {dt_reg, 12'd0})) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_ge ? (rem_shift - {1'b0, dt_reg}) : rem_shift;
                    low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
                    quot_reg <= {quot_reg[QUOT_W-2:0], rem_ge};
                    if (div_cnt_reg == 5'd0) begin
                        state_reg <= ST_FIN;
                    end else begin
                        div_cnt_reg <= div_cnt_reg - 5'd1;
                    end
                end
                ST_FIN: begin
                    if (dp_zero_reg) begin
                        speed_reg <= '0;
                    end else if (ovf_reg) begin
                        speed_reg <= neg_reg ? SPEED_MIN : SPEED_MAX;
                    end else if (neg_reg) begin
                        speed_reg <= -$signed({1'b0, quot_reg});
                    end else begin
                        speed_reg <= $signed({1'b0, quot_reg});
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid        <= 1'b1;
                        m_pulse_step   <= step_reg;
                        m_pulse_total  <= pulse_count_reg;
                        m_sample_event <= event_reg;
                        m_speed        <= speed_reg;
                        m_speed_valid  <= full_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("ring fill beyond depth");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_LAST)
        else $error("write slot beyond depth");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    a_speed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_speed_valid) |-> (m_speed == '0))
        else $error("speed nonzero with ring not full");

    a_event_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_event == (m_pulse_step != STEP_NONE)))
        else $error("sample event and step disagree");

endmodule

[tb/encoder_pulse_speed_meter_top_tb.sv]
// ---------------------------------------------------------------------------
// encoder_pulse_speed_meter_top_tb
// Polls go in with encoder level, millisecond time, direction hint and clear.
// A clocked driver sends them with random gaps, and a clocked monitor takes
// the results with random stalls. Each result beat is checked against a
// predictor of the count, the sample ring and the speed. Directed polls
// cover time wrap, the stop-time edge case, zero-span saturation and clear.
// Random phases then run at several stop times.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module encoder_pulse_speed_meter_top_tb;
    import epsm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_POLLS  = 192;

    typedef struct {
        logic              level;
        logic [31:0]       tms;
        logic signed [1:0] hint;
        logic              clr;
    } poll_t;

    typedef struct {
        logic signed [1:0]         step;
        logic signed [31:0]        total;
        logic                      sample;
        logic signed [SPEED_W-1:0] speed;
        logic                      speed_ok;
    } meter_reading_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [15:0]               cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_sensor_level = 1'b0;
    logic [31:0]               s_time_ms = '0;
    logic signed [1:0]         s_speed_sign = STEP_NONE;
    logic                      s_clear = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [1:0]         m_pulse_step;
    logic signed [31:0]        m_pulse_total;
    logic                      m_sample_event;
    logic signed [SPEED_W-1:0] m_speed;
    logic                      m_speed_valid;

    // predictor state
    logic [15:0] stop_time_cfg = STOP_TIME_RST;
    logic [31:0] pulse_count = '0;
    logic        last_level = 1'b0;
    logic        going_fwd = 1'b1;
    logic [31:0] time_ring [RING_DEPTH_DEF];
    logic [31:0] count_ring [RING_DEPTH_DEF];
    int          write_slot = 0;
    int          fill_level = 0;
    logic [31:0] last_edge_ms = '0;

    poll_t          poll_q [$];
    poll_t          poll_cur;
    meter_reading_t meter_readings_q [$];
    meter_reading_t want;

    int          polls_issued = 0;
    int          polls_accepted = 0;
    int          readings_checked = 0;
    int          mismatches = 0;
    int          edge_beats = 0;
    int          full_ring_beats = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          recv_hold = 0;
    int          recv_calm = 0;
    int          cycle_count = 0;
    int          failures;
    logic [31:0] gen_time = '0;
    logic        gen_level = 1'b0;
    logic [15:0] stop_plan [6];

    encoder_pulse_speed_meter_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_level (s_sensor_level),
        .s_time_ms      (s_time_ms),
        .s_speed_sign   (s_speed_sign),
        .s_clear        (s_clear),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pulse_step   (m_pulse_step),
        .m_pulse_total  (m_pulse_total),
        .m_sample_event (m_sample_event),
        .m_speed        (m_speed),
        .m_speed_valid  (m_speed_valid)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic meter_reading_t advance_meter(input poll_t p);
        meter_reading_t r;
        int             newest;
        int             oldest;
        int             dp_s;
        logic [31:0]    idle_ms;
        logic [31:0]    dt;
        logic [31:0]    dp_raw;
        longint         dp;
        longint unsigned mag;
        longint unsigned quot;
        if (p.clr) begin
            pulse_count  = '0;
            write_slot   = 0;
            fill_level   = 0;
            going_fwd    = 1'b1;
            last_edge_ms = p.tms;
        end
        if (p.hint == STEP_FWD) begin
            going_fwd = 1'b1;
        end else if (p.hint[1]) begin
            going_fwd = 1'b0;
        end
        r.step     = STEP_NONE;
        r.sample   = 1'b0;
        r.speed    = '0;
        r.speed_ok = 1'b0;
        idle_ms    = p.tms - last_edge_ms;
        if (p.level != last_level) begin
            r.step      = going_fwd ? STEP_FWD : STEP_REV;
            pulse_count = going_fwd ? pulse_count + 32'd1 : pulse_count - 32'd1;
            time_ring[write_slot]  = p.tms;
            count_ring[write_slot] = pulse_count;
            write_slot = (write_slot + 1) % RING_DEPTH_DEF;
            if (fill_level < RING_DEPTH_DEF) fill_level++;
            last_edge_ms = p.tms;
            r.sample     = 1'b1;
        end else if (idle_ms > {16'd0, stop_time_cfg}) begin
            fill_level   = 0;
            write_slot   = 0;
            last_edge_ms = p.tms;
        end
        last_level = p.level;
        r.total    = pulse_count;
        if (fill_level >= RING_DEPTH_DEF) begin
            r.speed_ok = 1'b1;
            newest = (write_slot + RING_DEPTH_DEF - 1) % RING_DEPTH_DEF;
            oldest = write_slot;
            dp_raw = count_ring[newest] - count_ring[oldest];
            dt     = time_ring[newest] - time_ring[oldest];
            dp_s   = dp_raw;
            dp     = dp_s;
            if (dt == 32'd0) begin
                r.speed = (dp > 0) ? SPEED_MAX : (dp < 0) ? SPEED_MIN : '0;
            end else begin
                mag  = (dp < 0) ? -dp : dp;
                quot = (mag * 64'd256000) / dt;
                if (dp < 0) begin
                    r.speed = (quot >= 64'd8388608) ? SPEED_MIN : -quot[SPEED_W-1:0];
                end else begin
                    r.speed = (quot > 64'd8388607) ? SPEED_MAX : quot[SPEED_W-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic push_poll(input logic level, input logic [31:0] tms,
                             input logic signed [1:0] hint, input logic clr);
        poll_t p;
        p.level = level;
        p.tms   = tms;
        p.hint  = hint;
        p.clr   = clr;
        poll_q.push_back(p);
        polls_issued++;
    endtask

    task automatic queue_random_polls(input int count);
        int r;
        int lim;
        logic signed [1:0] hint;
        for (int i = 0; i < count; i++) begin
            lim = (stop_time_cfg == 16'd0) ? 1 : int'(stop_time_cfg);
            r   = $urandom_range(0, 99);
            if (r < 60) begin
                gen_time += $urandom_range(0, lim / 3);
            end else if (r < 75) begin
                gen_time += lim + $urandom_range(0, 2) - 1;
            end else if (r < 85) begin
                gen_time += 0;
            end else if (r < 92) begin
                gen_time += $urandom_range(1, 20);
            end else if (r < 97) begin
                gen_time = $urandom;
            end else begin
                gen_time = 32'hFFFF_FFFF - $urandom_range(0, 40);
            end
            if ($urandom_range(0, 99) < 65) gen_level = ~gen_level;
            r    = $urandom_range(0, 99);
            hint = (r < 70) ? STEP_NONE : (r < 85) ? STEP_FWD : STEP_REV;
            push_poll(gen_level, gen_time, hint, $urandom_range(0, 99) < 2);
        end
    endtask

    task automatic wait_drained();
        while (polls_accepted != polls_issued || readings_checked != polls_accepted) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stop_time(input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        stop_time_cfg = value;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                meter_readings_q.push_back(advance_meter(poll_cur));
                polls_accepted++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (poll_q.size() > 0) begin
                poll_cur = poll_q.pop_front();
                s_sensor_level <= poll_cur.level;
                s_time_ms      <= poll_cur.tms;
                s_speed_sign   <= poll_cur.hint;
                s_clear        <= poll_cur.clr;
                s_valid        <= 1'b1;
                send_gap = draw_wait(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (meter_readings_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result beat with nothing pending: total %0d", m_pulse_total);
                    end
                end else begin
                    want = meter_readings_q.pop_front();
                    readings_checked++;
                    if (want.sample) edge_beats++;
                    if (want.speed_ok) full_ring_beats++;
                    if (m_pulse_step !== want.step || m_pulse_total !== want.total ||
                        m_sample_event !== want.sample || m_speed !== want.speed ||
                        m_speed_valid !== want.speed_ok) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result %0d (expected/actual): step %0d/%0d ",
                                      "total %0d/%0d event %0b/%0b speed %0d/%0d ",
                                      "valid %0b/%0b"},
                                     readings_checked, want.step, m_pulse_step,
                                     want.total, m_pulse_total, want.sample,
                                     m_sample_event, want.speed, m_speed,
                                     want.speed_ok, m_speed_valid);
                        end
                    end
                end
                recv_hold = draw_wait(recv_calm);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // time wrap across a full ring, then the stop-time boundary
        push_poll(1'b0, 32'd0, STEP_NONE, 1'b0);
        push_poll(1'b1, 32'hFFFF_FFFF, STEP_FWD, 1'b1);
        for (int k = 1; k <= 7; k++) begin
            push_poll(k % 2 == 0, 32'hFFFF_FFFF + 3 * k, (k == 4) ? STEP_FWD : STEP_NONE, 1'b0);
        end
        push_poll(1'b1, 32'd20, STEP_REV, 1'b0);
        push_poll(1'b1, 32'd520, STEP_NONE, 1'b0);
        push_poll(1'b1, 32'd1021, STEP_NONE, 1'b0);
        // zero time span, reverse then forward saturation
        push_poll(1'b0, 32'd5000, STEP_REV, 1'b1);
        for (int k = 1; k <= 7; k++) begin
            push_poll(1'(k % 2), 32'd5000, STEP_REV, 1'b0);
        end
        for (int k = 1; k <= 7; k++) begin
            push_poll(k % 2 == 0, 32'd5000, (k == 1) ? STEP_FWD : STEP_NONE, 1'b0);
        end
        push_poll(1'b0, 32'd5000, STEP_NONE, 1'b1);
        gen_time  = 32'd5000;
        gen_level = 1'b0;

        stop_plan[0] = 16'd1;
        stop_plan[1] = 16'hFFFF;
        stop_plan[2] = 16'd0;
        stop_plan[3] = 16'($urandom_range(2, 999));
        stop_plan[4] = 16'($urandom_range(1000, 65534));
        stop_plan[5] = STOP_TIME_RST;
        foreach (stop_plan[i]) begin
            wait_drained();
            write_stop_time(stop_plan[i]);
            queue_random_polls(PHASE_POLLS);
        end
        wait_drained();

        failures = mismatches + meter_readings_q.size();
        $display("covered %0d polls over %0d stop-time settings plus reset default",
                 polls_accepted, $size(stop_plan));
        $display("%0d edge results, %0d with a full ring, %0d mismatching beats",
                 edge_beats, full_ring_beats, failures);
        if (failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/epsm_pkg.sv
hw/rtl/encoder_pulse_speed_meter_top.sv
tb/encoder_pulse_speed_meter_top_tb.sv
